// ===== rtl/rotation_matrix_to_quaternion_assert.svh =====
// assertion macros for the pose to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// implication checked outside reset
`define RMQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rmq: implication failed");

// implication into the next cycle, checked during reset too
`define RMQ_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rmq: next-cycle check failed");

// a stalled transfer keeps valid and data
`define RMQ_ASSERT_HOLD(label, clk, rstn, vld, rdy, dat) \
    label: assert property (@(posedge clk) disable iff (!rstn) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(dat))) \
        else $error("rmq: stalled transfer changed");

`endif

// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int ROT_W     = 16;
    localparam int POS_W     = 32;
    localparam int RSUM_W    = 19;
    localparam int RAD_W     = 17;
    localparam int SQ_IN_W   = 32;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int NUM_CELLS = SQ_IN_W / 2;
    localparam int LANES     = 4;
    localparam int MAG_W     = 15;
    localparam int QV_W      = 16;
    localparam int IN_W      = 9 * ROT_W + 3 * POS_W;
    localparam int OUT_W     = 160;

    localparam logic signed [ROT_W-1:0]  ONE_ROT = ROT_W'(ONE);
    localparam logic signed [RSUM_W-1:0] ONE_SUM = RSUM_W'(ONE);

    typedef struct packed {
        logic [SQ_IN_W-1:0] rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } lane_t;

    typedef struct packed {
        logic             neg_x;
        logic             neg_y;
        logic             neg_z;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } side_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        side_t             side;
    } stage_t;

    function automatic logic signed [ROT_W-1:0] clamp_entry(
        input logic signed [ROT_W-1:0] v
    );
        logic signed [ROT_W-1:0] r;
        r = v;
        if (v > ONE_ROT) begin
            r = ONE_ROT;
        end else if (v < -ONE_ROT) begin
            r = -ONE_ROT;
        end
        return r;
    endfunction

endpackage

// ===== rtl/rmq_front.sv =====
`timescale 1ns / 1ps

module rmq_front
    import rmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  in_data,
    output logic             out_valid,
    output stage_t           out_stage
);

    logic signed [ROT_W-1:0]  m [9];
    logic signed [RSUM_W-1:0] m_ext [9];
    logic signed [RSUM_W-1:0] sum [LANES];
    stage_t                   stage_next;
    stage_t                   stage_reg;
    logic                     valid_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i]     = clamp_entry(in_data[i*ROT_W +: ROT_W]);
            m_ext[i] = RSUM_W'(m[i]);
        end
        // diagonal entries sit at 0, 4 and 8
        sum[0] = ONE_SUM + m_ext[0] + m_ext[4] + m_ext[8];
        sum[1] = ONE_SUM + m_ext[0] - m_ext[4] - m_ext[8];
        sum[2] = ONE_SUM - m_ext[0] + m_ext[4] - m_ext[8];
        sum[3] = ONE_SUM - m_ext[0] - m_ext[4] + m_ext[8];
        for (int l = 0; l < LANES; l++) begin
            stage_next.lane[l].rem  = '0;
            stage_next.lane[l].root = '0;
            if (sum[l] < 0) begin
                stage_next.lane[l].rad = '0;
            end else begin
                stage_next.lane[l].rad = {{(SQ_IN_W-RAD_W-FRAC_BITS){1'b0}},
                                          sum[l][RAD_W-1:0], {FRAC_BITS{1'b0}}};
            end
        end
        stage_next.side.neg_x = m[7] < m[5];
        stage_next.side.neg_y = m[2] < m[6];
        stage_next.side.neg_z = m[3] < m[1];
        stage_next.side.pos_x = in_data[9*ROT_W +: POS_W];
        stage_next.side.pos_y = in_data[9*ROT_W+POS_W +: POS_W];
        stage_next.side.pos_z = in_data[9*ROT_W+2*POS_W +: POS_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/rmq_cell.sv =====
`timescale 1ns / 1ps

module rmq_cell
    import rmq_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   out_valid,
    output stage_t out_stage
);

    logic [REM_W-1:0] rem_sh [LANES];
    logic [REM_W-1:0] trial  [LANES];
    stage_t           stage_next;
    stage_t           stage_reg;
    logic             valid_reg;

    // one root bit per cell for each lane
    always_comb begin
        stage_next.side = in_stage.side;
        for (int l = 0; l < LANES; l++) begin
            rem_sh[l] = {in_stage.lane[l].rem[REM_W-3:0],
                         in_stage.lane[l].rad[SQ_IN_W-1 -: 2]};
            trial[l]  = {1'b0, in_stage.lane[l].root, 2'b01};
            stage_next.lane[l].rad = {in_stage.lane[l].rad[SQ_IN_W-3:0], 2'b00};
            if (rem_sh[l] >= trial[l]) begin
                stage_next.lane[l].rem  = rem_sh[l] - trial[l];
                stage_next.lane[l].root = {in_stage.lane[l].root[ROOT_W-2:0], 1'b1};
            end else begin
                stage_next.lane[l].rem  = rem_sh[l];
                stage_next.lane[l].root = {in_stage.lane[l].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/rmq_back.sv =====
`timescale 1ns / 1ps

module rmq_back
    import rmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  stage_t           in_stage,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data
);

    logic [MAG_W-1:0] mag [LANES];
    logic [QV_W-1:0]  qx;
    logic [QV_W-1:0]  qy;
    logic [QV_W-1:0]  qz;
    logic [OUT_W-1:0] data_next;
    logic [OUT_W-1:0] data_reg;
    logic             valid_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            mag[l] = in_stage.lane[l].root[ROOT_W-1:1];
        end
        qx = in_stage.side.neg_x ? (QV_W'(0) - {1'b0, mag[1]}) : {1'b0, mag[1]};
        qy = in_stage.side.neg_y ? (QV_W'(0) - {1'b0, mag[2]}) : {1'b0, mag[2]};
        qz = in_stage.side.neg_z ? (QV_W'(0) - {1'b0, mag[3]}) : {1'b0, mag[3]};
        data_next = {1'b0, in_stage.side.pos_z, in_stage.side.pos_y, in_stage.side.pos_x,
                     qz, qy, qx, mag[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// path from s_ transfer to m_ transfer: input stage, 16 root cells, output stage, each registered
// throughput: one pose per cycle unless the chain is held;
// each of the 16 cells retires one root bit of all four lanes
// the whole chain advances together and holds while a result waits on m_tready
// reset: synchronous, active low, clears every stage valid bit; payload is not reset
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    // pos_x_in, pos_y_in, pos_z_in
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // quat_w, quat_x, quat_y, quat_z, pos_x_out, pos_y_out, pos_z_out, one zero pad bit
    output logic [OUT_W-1:0] m_tdata
);

    logic   adv;
    logic   valid_chain [NUM_CELLS+1];
    stage_t stage_chain [NUM_CELLS+1];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (valid_chain[0]),
        .out_stage (stage_chain[0])
    );

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        rmq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (valid_chain[c]),
            .in_stage  (stage_chain[c]),
            .out_valid (valid_chain[c+1]),
            .out_stage (stage_chain[c+1])
        );
    end

    rmq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (valid_chain[NUM_CELLS]),
        .in_stage  (stage_chain[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

// ===== rtl/rmq_checker.sv =====
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_checker
    import rmq_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    `RMQ_ASSERT_NEXT(a_reset_clears, aclk, !aresetn, !m_tvalid)
    `RMQ_ASSERT_IMPL(a_ready_follows_out, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))
    `RMQ_ASSERT_IMPL(a_w_bound, aclk, aresetn, m_tvalid, m_tdata[14:0] <= 15'd16384)
    `RMQ_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[159] == 1'b0)
    `RMQ_ASSERT_HOLD(a_out_hold, aclk, aresetn, m_tvalid, m_tready, m_tdata)

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
